@@ rtl/chained_hash_map_engine_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the chained hash map engine
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHM_ASSERT_IMP(label, clk, rst, ante, cons)
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg
// shared types and constants of the chained hash map engine
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int NumBucketsDefault = 256;
  localparam int SlotsPerBucketDefault = 4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;
  localparam logic [1:0] REG_COEF_A       = 2'd1;
  localparam logic [1:0] REG_COEF_B       = 2'd2;
  localparam logic [1:0] REG_COEF_C       = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM,
    ST_DIV, ST_FIX, ST_SCAN, ST_WAIT, ST_WRITE, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic div_start;
    logic div_step;
    logic fix;
    logic scan_start;
    logic scan_step;
    logic write;
    logic clear_step;
    logic respond;
  } ctrl_t;

  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic clear_last;
  } stat_t;

endpackage

@@ rtl/chm_datapath.sv @@
// ----------------------------------------------------------------------------
// chm_datapath
// hash arithmetic, serial remainder, bucket memories and result registers
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_macros.svh"
module chm_datapath #(
  parameter int NUM_BUCKETS = chm_pkg::NumBucketsDefault,
  parameter int SLOTS_PER_BUCKET = chm_pkg::SlotsPerBucketDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          opcode,
  input  logic [31:0]         key,
  input  logic [31:0]         new_value,
  input  chm_pkg::ctrl_t      ctrl,
  output chm_pkg::stat_t      stat,
  output logic                found,
  output logic [31:0]         read_value,
  output logic                status
);
  import chm_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW = $clog2(TOTAL);
  localparam int MW = $clog2(NUM_BUCKETS + 1);
  localparam int CW = (MW > 9) ? MW : 9;

  logic [8:0]  bucket_count;
  logic [31:0] coef_a, coef_b, coef_c;
  logic [1:0]  op;
  logic [31:0] k, v;
  logic [31:0] sq, t1, t2, h, absh;
  logic        neg;
  logic [MW-1:0] m;
  logic [MW:0]   rem;
  logic [4:0]  dcnt;
  logic [BW-1:0] bucket;
  logic [SW:0] scnt;
  logic [SW:0] rcnt;
  logic        rvld;
  logic        hit, has_free;
  logic [SW-1:0] hit_s, free_s;
  logic [AW-1:0] clr;
  logic        valid [TOTAL];
  logic [31:0] mkey [TOTAL];
  logic [31:0] mval [TOTAL];
  logic [31:0] rkey, rval;
  logic        rv;
  logic [31:0] hval;

  logic [CW-1:0] bc_ext;
  logic [MW:0]   rem_sh;
  logic [AW-1:0] base, raddr, waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 9'd100;
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BUCKET_COUNT: bucket_count <= cfg_data[8:0];
        REG_COEF_A: coef_a <= cfg_data;
        REG_COEF_B: coef_b <= cfg_data;
        REG_COEF_C: coef_c <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bc_ext = CW'(bucket_count);
  assign rem_sh = {rem[MW-1:0], absh[31]};
  assign base = AW'(bucket) * AW'(SLOTS_PER_BUCKET);
  assign raddr = base + AW'(scnt[SW-1:0]);
  assign waddr = hit ? (base + AW'(hit_s)) : (base + AW'(free_s));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op <= opcode;
      k <= key;
      v <= new_value;
      if (bc_ext == '0) m <= MW'(1);
      else if (bc_ext > CW'(NUM_BUCKETS)) m <= MW'(NUM_BUCKETS);
      else m <= MW'(bc_ext);
    end
    if (ctrl.mul1) sq <= k * k;
    if (ctrl.mul2) t1 <= coef_a * sq;
    if (ctrl.mul3) t2 <= coef_b * k;
    if (ctrl.sum) h <= t1 + t2 + coef_c;
    if (ctrl.div_start) begin
      neg <= h[31];
      absh <= h[31] ? (32'd0 - h) : h;
      rem <= '0;
      dcnt <= '0;
    end
    if (ctrl.div_step) begin
      absh <= {absh[30:0], 1'b0};
      rem <= (rem_sh >= {1'b0, m}) ? rem_sh - {1'b0, m} : rem_sh;
      dcnt <= dcnt + 5'd1;
    end
    if (ctrl.fix) begin
      if (neg && rem != '0) bucket <= BW'({1'b0, m} - rem);
      else bucket <= BW'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      scnt <= '0;
      hit <= 1'b0;
      has_free <= 1'b0;
    end else if (ctrl.scan_step && scnt != (SW+1)'(SLOTS_PER_BUCKET)) begin
      scnt <= scnt + 1'b1;
    end
    if (rst) rvld <= 1'b0;
    else rvld <= ctrl.scan_step && scnt != (SW+1)'(SLOTS_PER_BUCKET);
    rcnt <= scnt;
    rkey <= mkey[raddr];
    rval <= mval[raddr];
    rv <= valid[raddr];
    if (rvld) begin
      if (rv) begin
        if (!hit && rkey == k) begin
          hit <= 1'b1;
          hit_s <= rcnt[SW-1:0];
          hval <= rval;
        end
      end else if (!has_free) begin
        has_free <= 1'b1;
        free_s <= rcnt[SW-1:0];
      end
    end
  end

  always_comb begin
    stat.div_last = (dcnt == 5'd31);
    stat.scan_last = (rcnt == (SW+1)'(SLOTS_PER_BUCKET - 1)) && rvld;
    stat.clear_last = (clr == AW'(TOTAL - 1));
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      if ((op == OP_INSERT) && (hit || has_free)) begin
        mval[waddr] <= v;
        mkey[waddr] <= k;
      end else if ((op == OP_LOOKUP) && !hit && has_free) begin
        mval[waddr] <= '0;
        mkey[waddr] <= k;
      end
    end
  end

  // clearing pass walks every slot once after reset
  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (ctrl.clear_step) clr <= clr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear_step) begin
      valid[clr] <= 1'b0;
    end else if (ctrl.write) begin
      if ((op == OP_INSERT || op == OP_LOOKUP) && !hit && has_free)
        valid[waddr] <= 1'b1;
      else if (op == OP_ERASE && hit)
        valid[waddr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      found <= (op != OP_UNUSED) && hit;
      read_value <= (op == OP_LOOKUP && hit) ? hval : '0;
      status <= (op == OP_INSERT || op == OP_LOOKUP) && !hit && !has_free;
    end
  end

  `CHM_ASSERT_IMP(a_bucket_range, clk, rst, ctrl.scan_step, {1'b0, bucket} < (BW+1)'(m))
  `CHM_ASSERT_IMP(a_status_no_found, clk, rst, ctrl.respond, !(found && status))
  `CHM_ASSERT_NEXT(a_clr_idle, clk, rst, !ctrl.clear_step, $stable(clr))

endmodule

@@ rtl/chm_controller.sv @@
// ----------------------------------------------------------------------------
// chm_controller
// sequences hash, remainder, bucket scan and update for one transaction
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_macros.svh"
module chm_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output chm_pkg::ctrl_t  ctrl,
  input  chm_pkg::stat_t  stat
);
  import chm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctrl.clear_step = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin ctrl.mul1 = 1'b1; state_next = ST_MUL2; end
      ST_MUL2: begin ctrl.mul2 = 1'b1; state_next = ST_MUL3; end
      ST_MUL3: begin ctrl.mul3 = 1'b1; state_next = ST_SUM; end
      ST_SUM: begin ctrl.sum = 1'b1; state_next = ST_DIV; end
      ST_DIV: begin
        ctrl.div_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        ctrl.div_step = 1'b1;
        if (stat.div_last) state_next = ST_FIX;
      end
      ST_FIX: begin
        ctrl.fix = 1'b1;
        ctrl.scan_start = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) state_next = ST_WRITE;
      end
      ST_WRITE: begin ctrl.write = 1'b1; state_next = ST_DONE; end
      ST_DONE: begin ctrl.respond = 1'b1; done = 1'b1; state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end

  `CHM_ASSERT_NEXT(a_start_leaves_idle, clk, rst, start && !busy, busy)
  `CHM_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done && !busy)
  `CHM_ASSERT_IMP(a_load_only_idle, clk, rst, ctrl.load, !busy)

endmodule

@@ rtl/chained_hash_map_engine.sv @@
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// key-to-value table with quadratic hash into fixed-size buckets
// ----------------------------------------------------------------------------
// usage: raise start with opcode, key and new_value while busy is low; the
// transaction is taken at that edge and busy rises. the result (found,
// read_value, status) appears for one cycle with done high; there is no
// stall on the result side. configuration is written through cfg_write,
// cfg_index and cfg_data while busy is low.
// sequence: after the accepting edge the engine runs three registered
// multiplies, one sum, one remainder setup, a 32-step radix-2 remainder
// by the bucket count, one bucket fix, a slot scan of one memory read per
// slot plus one, one write and one done cycle. busy drops the cycle after
// done, so one transaction runs at a time.
// reset: synchronous; registers return to their reset values, then a
// clearing pass visits each slot in turn and clears the valid bits with
// busy held high.
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_macros.svh"
module chained_hash_map_engine #(
  parameter int NUM_BUCKETS = chm_pkg::NumBucketsDefault,
  parameter int SLOTS_PER_BUCKET = chm_pkg::SlotsPerBucketDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [31:0] new_value,
  output logic        done,
  output logic        found,
  output logic [31:0] read_value,
  output logic        status
);
  import chm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  chm_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .ctrl(ctrl), .stat(stat)
  );

  chm_datapath #(
    .NUM_BUCKETS(NUM_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .opcode(opcode), .key(key), .new_value(new_value),
    .ctrl(ctrl), .stat(stat), .found(found), .read_value(read_value),
    .status(status)
  );

endmodule

@@ bench/hash_map_checker.sv @@
// ----------------------------------------------------------------------------
// hash_map_checker
// Tracks the engine's configuration and table contents from the transactions
// it sees. For each accepted command it computes the expected found,
// read_value and status. Each done strobe is compared with the oldest
// expected result.
// ----------------------------------------------------------------------------
module hash_map_checker #(
  parameter int NUM_BUCKETS = 256,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [31:0] new_value,
  input  logic        done,
  input  logic        found,
  input  logic [31:0] read_value,
  input  logic        status,
  output int          fail_count,
  output int          pending
);
  import chm_pkg::*;

  localparam int TotalSlots = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int FifoDepth = 8;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        status;
  } access_result_t;

  logic [8:0]  bucket_count_q;
  logic [31:0] coef_a_q, coef_b_q, coef_c_q;
  logic        table_valid [TotalSlots];
  logic [31:0] table_key [TotalSlots];
  logic [31:0] table_value [TotalSlots];
  access_result_t expected_fifo [FifoDepth];
  int          wr_ptr, rd_ptr;

  assign pending = wr_ptr - rd_ptr;

  function automatic int bucket_index(logic [31:0] k);
    logic [31:0] m, h, r;
    m = (bucket_count_q == 0) ? 32'd1 :
        (bucket_count_q > NUM_BUCKETS) ? 32'(NUM_BUCKETS) : 32'(bucket_count_q);
    h = coef_a_q * k * k + coef_b_q * k + coef_c_q;
    if (!h[31]) return int'(h % m);
    r = (32'd0 - h) % m;
    return (r == 0) ? 0 : int'(m - r);
  endfunction

  function automatic access_result_t predict_access(logic [1:0] op, logic [31:0] k,
                                                    logic [31:0] v);
    access_result_t res;
    int base, hit, free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    if (op == OP_UNUSED) return res;
    base = bucket_index(k) * SLOTS_PER_BUCKET;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (table_valid[base + s]) begin
        if (hit < 0 && table_key[base + s] == k) hit = base + s;
      end else if (free_slot < 0) begin
        free_slot = base + s;
      end
    end
    res.found = (hit >= 0);
    case (op)
      OP_INSERT: begin
        if (hit >= 0) table_value[hit] = v;
        else if (free_slot >= 0) begin
          table_valid[free_slot] = 1'b1;
          table_key[free_slot] = k;
          table_value[free_slot] = v;
        end else res.status = 1'b1;
      end
      OP_ERASE: begin
        if (hit >= 0) table_valid[hit] = 1'b0;
      end
      default: begin
        if (hit >= 0) res.read_value = table_value[hit];
        else if (free_slot >= 0) begin
          table_valid[free_slot] = 1'b1;
          table_key[free_slot] = k;
          table_value[free_slot] = 32'd0;
        end else res.status = 1'b1;
      end
    endcase
    return res;
  endfunction

  initial begin
    fail_count = 0;
    wr_ptr = 0;
    rd_ptr = 0;
  end

  always @(posedge clk) begin
    access_result_t exp_res;
    if (rst) begin
      bucket_count_q <= 9'd100;
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      for (int i = 0; i < TotalSlots; i++) table_valid[i] = 1'b0;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BUCKET_COUNT: bucket_count_q <= cfg_data[8:0];
          REG_COEF_A:       coef_a_q <= cfg_data;
          REG_COEF_B:       coef_b_q <= cfg_data;
          REG_COEF_C:       coef_c_q <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (wr_ptr - rd_ptr >= FifoDepth) begin
          $display("%0t: too many transactions in flight", $time);
          fail_count++;
        end else begin
          expected_fifo[wr_ptr % FifoDepth] = predict_access(opcode, key, new_value);
          wr_ptr++;
        end
      end
      if (done) begin
        if (wr_ptr == rd_ptr) begin
          $display("%0t: unexpected transaction: found %b read_value %h status %b",
                   $time, found, read_value, status);
          fail_count++;
        end else begin
          exp_res = expected_fifo[rd_ptr % FifoDepth];
          rd_ptr++;
          if (found !== exp_res.found) begin
            $display("%0t: found expected %b actual %b", $time, exp_res.found, found);
            fail_count++;
          end
          if (read_value !== exp_res.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     exp_res.read_value, read_value);
            fail_count++;
          end
          if (status !== exp_res.status) begin
            $display("%0t: status expected %b actual %b", $time, exp_res.status, status);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ bench/chained_hash_map_engine_tb.sv @@
// ----------------------------------------------------------------------------
// chained_hash_map_engine_tb
// Drives insert, erase and lookup commands into the hash map engine. A
// directed part covers key extremes, full buckets and the unused opcode.
// Random phases follow under several hash settings and sender idle rates.
// Checking is done by hash_map_checker.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_tb;
  import chm_pkg::*;

  localparam int CycleLimit = 1000000;

  logic        clk, rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        start, busy;
  logic [1:0]  opcode;
  logic [31:0] key, new_value;
  logic        done, found, status;
  logic [31:0] read_value;
  int          fail_count, pending;
  int          cycles;
  int          idle_pct;
  logic [31:0] key_pool [16];

  chained_hash_map_engine uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode), .key(key),
    .new_value(new_value), .done(done), .found(found), .read_value(read_value),
    .status(status)
  );

  hash_map_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode), .key(key),
    .new_value(new_value), .done(done), .found(found), .read_value(read_value),
    .status(status), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue_command(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    key <= k;
    new_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (pending == 0) break;
    end
    repeat (50) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_hash(logic [8:0] bc, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    cfg_write <= 1'b1;
    cfg_index <= REG_BUCKET_COUNT;
    cfg_data <= 32'(bc);
    @(negedge clk);
    cfg_index <= REG_COEF_A;
    cfg_data <= a;
    @(negedge clk);
    cfg_index <= REG_COEF_B;
    cfg_data <= b;
    @(negedge clk);
    cfg_index <= REG_COEF_C;
    cfg_data <= c;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int n);
    logic [1:0]  op;
    logic [31:0] k;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(49) == 0) ? OP_UNUSED : 2'($urandom_range(2));
      k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : $urandom();
      issue_command(op, k, $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_BUCKET_COUNT;
    cfg_data = '0;
    start = 1'b0;
    opcode = OP_INSERT;
    key = '0;
    new_value = '0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset hash sends every key to bucket 0
    issue_command(OP_LOOKUP, 32'h8000_0000, 32'h0);
    issue_command(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    issue_command(OP_LOOKUP, 32'h8000_0000, 32'h0);
    issue_command(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    issue_command(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    issue_command(OP_LOOKUP, 32'h7fff_ffff, 32'h0);
    issue_command(OP_INSERT, 32'hffff_ffff, 32'h0);
    issue_command(OP_INSERT, 32'h0, 32'h1234_5678);
    issue_command(OP_INSERT, 32'h5, 32'h1);
    issue_command(OP_LOOKUP, 32'h6, 32'h0);
    issue_command(OP_ERASE, 32'h7fff_ffff, 32'h0);
    issue_command(OP_ERASE, 32'h7fff_ffff, 32'h0);
    issue_command(OP_LOOKUP, 32'h6, 32'h0);
    issue_command(OP_LOOKUP, 32'h6, 32'h0);
    issue_command(OP_INSERT, 32'h8, 32'h9);
    issue_command(OP_UNUSED, 32'h0, 32'hffff_ffff);
    issue_command(OP_ERASE, 32'h8000_0000, 32'h0);
    issue_command(OP_LOOKUP, 32'hffff_ffff, 32'h0);
    drain();

    // hash settings: bucket count extremes and coefficient extremes
    load_hash(9'd256, 32'h0, 32'h1, 32'h0);
    idle_pct = 0;
    random_phase(230);
    drain();
    load_hash(9'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    idle_pct = 69;
    random_phase(230);
    drain();
    load_hash(9'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    idle_pct = 13;
    random_phase(230);
    drain();
    load_hash(9'd511, $urandom(), $urandom(), $urandom());
    idle_pct = 69;
    random_phase(230);
    drain();
    load_hash(9'($urandom_range(2, 255)), $urandom(), $urandom(), 32'h7fff_ffff);
    idle_pct = 0;
    random_phase(230);
    drain();
    load_hash(9'd3, 32'h0, 32'h0, 32'h8000_0000);
    idle_pct = 13;
    random_phase(230);
    drain();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
